[design/sust_pkg.sv]
// ----------------------------------------------------------------------------
// sust_pkg
// shared types and codes for the sorted unique set table
// ----------------------------------------------------------------------------
package sust_pkg;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_TEST   = 3'd2,
		ACT_READ   = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		STS_DONE     = 3'd0,
		STS_NOCHANGE = 3'd1,
		STS_FULL     = 3'd2,
		STS_NUMRANGE = 3'd3,
		STS_IDXRANGE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_EXEC,
		ST_SHUP,
		ST_INS,
		ST_SHDN,
		ST_RDX,
		ST_RDW,
		ST_OUT
	} state_t;

	localparam int unsigned FC_W    = 17;
	localparam int unsigned NUM_W   = 16;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned COUNT_W = 9;
	localparam logic [FC_W-1:0] FC_RESET = 17'h10000;

endpackage

[design/sorted_unique_set_table.sv]
// ----------------------------------------------------------------------------
// sorted_unique_set_table
// ascending duplicate-free list of feature numbers in a one-read one-write store
// ----------------------------------------------------------------------------
// One word is handled at a time; in_stall stays high until its result has
// been placed in the output register, which can still hold the previous
// result while the next word is worked on. Add, remove and test first scan
// the store from the bottom, one entry per cycle through the registered read
// port. An add then moves every larger entry up one place and a remove moves
// every later entry down one place, again one entry per cycle. The scan stops
// where the move starts, so the worst case per word is an add below every
// entry of a list that holds CAPACITY-1 entries. A read at an index passes
// through an index check, a store read and the result step; clear and unknown
// actions go straight to the result step. Each word returns the block to idle
// before the next is taken; a stalled output holds it in its result step.
// The store itself is never cleared; only the entry count is reset.
module sorted_unique_set_table
	import sust_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [FC_W-1:0]      field_count,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [NUM_W-1:0]     feature_number,
	input  logic [IDX_W-1:0]     entry_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic                 present,
	output logic [NUM_W-1:0]     read_value,
	output logic [COUNT_W-1:0]   entry_count
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [NUM_W-1:0] mem [CAPACITY];

	state_t           state_q, state_d;
	logic [2:0]       act_q;
	logic [NUM_W-1:0] num_q;
	logic [IDX_W-1:0] idx_q;
	logic [CW-1:0]    pos_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    cnt_q;
	logic             pv_q;
	logic             found_q;
	logic [FC_W-1:0]  fc_q;
	logic [NUM_W-1:0] rd_q;
	logic [2:0]       res_status_q;
	logic             res_present_q;
	logic [NUM_W-1:0] res_rv_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic             present_q;
	logic [NUM_W-1:0] read_value_q;
	logic [COUNT_W-1:0] count_q;

	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [NUM_W-1:0] mem_wdata;

	logic             in_acc;
	logic             out_free;
	logic [CW-1:0]    pos_inc;
	logic             rd_ge;
	logic             srch_stop;
	logic             srch_found;
	logic [CW-1:0]    srch_pos;
	logic             num_bad;
	logic             full;
	logic             add_ok;
	logic             rem_ok;
	logic [CW+7:0]    idx_wide;
	logic [CW+7:0]    cnt_wide8;
	logic             idx_ok;
	logic [AW+7:0]    idx_addr;
	logic [CW+8:0]    cnt_wide9;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign pos_inc    = pos_q + CW'(1);
	assign rd_ge      = (rd_q >= num_q);
	assign srch_stop  = pv_q ? (rd_ge || (pos_inc == cnt_q)) : (cnt_q == '0);
	assign srch_found = pv_q && (rd_q == num_q);
	assign srch_pos   = (pv_q && !rd_ge) ? cnt_q : pos_q;

	assign num_bad = ({1'b0, num_q} >= fc_q);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign add_ok  = (act_q == ACT_ADD) && !num_bad && !found_q && !full;
	assign rem_ok  = (act_q == ACT_REMOVE) && !num_bad && found_q;

	assign idx_wide  = {{CW{1'b0}}, idx_q};
	assign cnt_wide8 = {8'b0, cnt_q};
	assign idx_ok    = (idx_wide < cnt_wide8);
	assign idx_addr  = {{AW{1'b0}}, idx_q};
	assign cnt_wide9 = {9'b0, cnt_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (action == ACT_ADD || action == ACT_REMOVE || action == ACT_TEST) begin
						state_d = ST_SRCH;
					end else if (action == ACT_READ) begin
						state_d = ST_RDX;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SRCH: begin
				if (srch_stop) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (add_ok) begin
					state_d = (pos_q == cnt_q) ? ST_INS : ST_SHUP;
				end else if (rem_ok && (pos_inc != cnt_q)) begin
					state_d = ST_SHDN;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SHUP: begin
				if ((k_q - CW'(1)) == pos_q) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				state_d = ST_OUT;
			end
			ST_SHDN: begin
				if ((k_q + CW'(2)) == cnt_q) begin
					state_d = ST_OUT;
				end
			end
			ST_RDX: begin
				state_d = idx_ok ? ST_RDW : ST_OUT;
			end
			ST_RDW: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// store port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_q;
		case (state_q)
			ST_SRCH: begin
				if (!srch_stop) begin
					mem_re    = 1'b1;
					mem_raddr = pv_q ? pos_inc[AW-1:0] : pos_q[AW-1:0];
				end
			end
			ST_EXEC: begin
				if (add_ok && (pos_q != cnt_q)) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(cnt_q - CW'(1));
				end else if (rem_ok && (pos_inc != cnt_q)) begin
					mem_re    = 1'b1;
					mem_raddr = pos_inc[AW-1:0];
				end
			end
			ST_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				if ((k_q - CW'(1)) != pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(k_q - CW'(2));
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = num_q;
			end
			ST_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				if ((k_q + CW'(2)) != cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(k_q + CW'(2));
				end
			end
			ST_RDX: begin
				if (idx_ok) begin
					mem_re    = 1'b1;
					mem_raddr = idx_addr[AW-1:0];
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fc_q        <= FC_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				fc_q <= field_count;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_CLEAR) begin
						cnt_q <= '0;
					end
				end
				ST_EXEC: begin
					if (rem_ok && (pos_inc == cnt_q)) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_INS: begin
					cnt_q <= cnt_q + CW'(1);
				end
				ST_SHDN: begin
					if ((k_q + CW'(2)) == cnt_q) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// datapath and result words
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					act_q         <= action;
					num_q         <= feature_number;
					idx_q         <= entry_index;
					pos_q         <= '0;
					pv_q          <= 1'b0;
					res_present_q <= 1'b0;
					res_rv_q      <= '0;
					res_status_q  <= (action == ACT_CLEAR) ? STS_DONE : STS_NOCHANGE;
				end
			end
			ST_SRCH: begin
				if (srch_stop) begin
					pos_q   <= srch_pos;
					found_q <= srch_found;
				end else if (!pv_q) begin
					pv_q <= 1'b1;
				end else begin
					pos_q <= pos_inc;
				end
			end
			ST_EXEC: begin
				res_present_q <= found_q;
				if (num_bad) begin
					res_status_q <= STS_NUMRANGE;
				end else if (act_q == ACT_ADD) begin
					if (found_q) begin
						res_status_q <= STS_NOCHANGE;
					end else if (full) begin
						res_status_q <= STS_FULL;
					end else begin
						res_status_q <= STS_DONE;
					end
				end else if (act_q == ACT_REMOVE) begin
					res_status_q <= found_q ? STS_DONE : STS_NOCHANGE;
				end else begin
					res_status_q <= STS_DONE;
				end
				k_q <= (act_q == ACT_ADD) ? cnt_q : pos_q;
			end
			ST_SHUP: begin
				k_q <= k_q - CW'(1);
			end
			ST_SHDN: begin
				k_q <= k_q + CW'(1);
			end
			ST_RDX: begin
				res_status_q <= idx_ok ? STS_DONE : STS_IDXRANGE;
			end
			ST_RDW: begin
				res_rv_q <= rd_q;
			end
			ST_OUT: begin
				if (out_free) begin
					status_q     <= res_status_q;
					present_q    <= res_present_q;
					read_value_q <= res_rv_q;
					count_q      <= cnt_wide9[COUNT_W-1:0];
				end
			end
			default: begin
				pv_q <= pv_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign present     = present_q;
	assign read_value  = read_value_q;
	assign entry_count = count_q;

	// count stays within the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= CAPACITY)
		else $error("entry count above capacity");

	// writes never land above the current end of the list
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) <= 32'(cnt_q)))
		else $error("store write beyond entry count");

	// an accepted word always leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted word not started");

	// result register loaded only when it is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT))
		else $error("result lost while output stalled");

endmodule
